[sv/lcs_pkg.sv]
// ---------------------------------------------------------------------------
// lcs_pkg
// Shared widths, types and register codes for the line centroid steering block
// ---------------------------------------------------------------------------
package lcs_pkg;

  // sample and sensor geometry
  localparam int SAMPLE_BITS = 10;
  localparam int NUM_SENSORS = 5;

  // configuration registers
  localparam int BASE_W     = 10;
  localparam int GAIN_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_ADDR_W = 1;
  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(200);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(3277);

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_BASE_SPEED = 1'b0,
    CFG_GAIN_Q16   = 1'b1
  } cfg_idx_t;

  // datapath widths
  localparam int MAG_W  = SAMPLE_BITS + 2;       // |weighted sum| <= 3 * max sample
  localparam int PSUM_W = SAMPLE_BITS + 3;       // plain sum of five samples
  localparam int P1_W   = MAG_W + GAIN_W;        // mag * gain
  localparam int P2_W   = P1_W + BASE_W;         // mag * gain * base
  localparam int NUM_W  = P2_W - GAIN_W;         // product with the Q0.16 scaling dropped
  localparam int Q_W    = BASE_W + 1;            // correction stays below 2 * base
  localparam int REM0_W = NUM_W - Q_W;           // leading numerator bits, below divisor
  localparam int OUT_W  = 13;

  // divider split over three stages
  localparam int DIV_STEPS_A = (Q_W + 2) / 3;
  localparam int DIV_STEPS_C = Q_W - 2 * DIV_STEPS_A;

  // stream widths
  localparam int IN_DATA_W  = ((NUM_SENSORS * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * OUT_W + 7) / 8) * 8;

  // sideband that travels with an item through the divider
  typedef struct packed {
    logic              neg;
    logic              zero;
    logic [BASE_W-1:0] base;
  } lcs_side_t;

endpackage

[sv/lcs_div.sv]
// ---------------------------------------------------------------------------
// lcs_div
// Three-stage pipelined restoring divider with stream handshake and sideband
// ---------------------------------------------------------------------------
module lcs_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [lcs_pkg::NUM_W-1:0]        in_num,
  input  logic [lcs_pkg::PSUM_W-1:0]       in_den,
  input  lcs_pkg::lcs_side_t               in_side,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [lcs_pkg::Q_W-1:0]          out_quo,
  output lcs_pkg::lcs_side_t               out_side
);

  typedef struct packed {
    logic [lcs_pkg::PSUM_W-1:0] rem;
    logic [lcs_pkg::Q_W-1:0]    low;
    logic [lcs_pkg::Q_W-1:0]    quo;
  } div_st_t;

  // a few restoring steps: shift in the next numerator bit, subtract if it fits
  function automatic div_st_t div_steps(input div_st_t st,
                                        input logic [lcs_pkg::PSUM_W-1:0] den,
                                        input int nsteps);
    div_st_t                  r;
    logic [lcs_pkg::PSUM_W:0] t;
    r = st;
    for (int i = 0; i < lcs_pkg::DIV_STEPS_A; i++) begin
      if (i < nsteps) begin
        t = {r.rem, r.low[lcs_pkg::Q_W-1]};
        r.low = {r.low[lcs_pkg::Q_W-2:0], 1'b0};
        if (t >= {1'b0, den}) begin
          t = t - {1'b0, den};
          r.quo = {r.quo[lcs_pkg::Q_W-2:0], 1'b1};
        end else begin
          r.quo = {r.quo[lcs_pkg::Q_W-2:0], 1'b0};
        end
        r.rem = t[lcs_pkg::PSUM_W-1:0];
      end
    end
    return r;
  endfunction

  div_st_t                    st0;
  div_st_t                    st_a_r, st_b_r, st_c_r;
  div_st_t                    st_a_nxt, st_b_nxt, st_c_nxt;
  logic [lcs_pkg::PSUM_W-1:0] den_a_r, den_b_r;
  lcs_pkg::lcs_side_t         side_a_r, side_b_r, side_c_r;
  logic                       v_a_r, v_b_r, v_c_r;
  logic                       en_a, en_b, en_c;

  // stage enables: a stage loads when empty or when its content moves on
  assign en_c     = !v_c_r || out_ready;
  assign en_b     = !v_b_r || en_c;
  assign en_a     = !v_a_r || en_b;
  assign in_ready = en_a;

  // leading numerator bits form the first partial remainder
  assign st0.rem = {{(lcs_pkg::PSUM_W - lcs_pkg::REM0_W){1'b0}},
                    in_num[lcs_pkg::NUM_W-1:lcs_pkg::Q_W]};
  assign st0.low = in_num[lcs_pkg::Q_W-1:0];
  assign st0.quo = '0;

  // step logic per stage
  always_comb begin
    st_a_nxt = div_steps(st0,    in_den,  lcs_pkg::DIV_STEPS_A);
    st_b_nxt = div_steps(st_a_r, den_a_r, lcs_pkg::DIV_STEPS_A);
    st_c_nxt = div_steps(st_b_r, den_b_r, lcs_pkg::DIV_STEPS_C);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
    end else begin
      if (en_a) v_a_r <= in_valid;
      if (en_b) v_b_r <= v_a_r;
      if (en_c) v_c_r <= v_b_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en_a) begin
      st_a_r   <= st_a_nxt;
      den_a_r  <= in_den;
      side_a_r <= in_side;
    end
    if (en_b) begin
      st_b_r   <= st_b_nxt;
      den_b_r  <= den_a_r;
      side_b_r <= side_a_r;
    end
    if (en_c) begin
      st_c_r   <= st_c_nxt;
      side_c_r <= side_b_r;
    end
  end

  assign out_valid = v_c_r;
  assign out_quo   = st_c_r.quo;
  assign out_side  = side_c_r;

endmodule

[sv/line_centroid_p_steering.sv]
// ---------------------------------------------------------------------------
// line_centroid_p_steering
// Proportional steering from the weighted centroid of five line sensors
// ---------------------------------------------------------------------------
// Each input beat carries five sensor samples; each output beat carries the
// left and right motor speeds, base minus and plus the correction
// (weighted sum * gain * base) / (plain sum * 65536), truncated toward zero,
// and a flag set when the sample sum is zero (both speeds then equal base).
// One beat is accepted every cycle while the output side is not stalling; a
// result passes one stage for the sums, two for the multiplier chain, three
// for the restoring divider (quotient bits split four, four, three) and the
// output register. Stalls on the output side back up stage by stage, so
// empty stages still fill.
// ---------------------------------------------------------------------------
module line_centroid_p_steering (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // sensor_0, sensor_1, sensor_2, sensor_3, sensor_4, zero fill
  input  logic [lcs_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // left_rpm, right_rpm, zero fill
  output logic [lcs_pkg::OUT_DATA_W-1:0]     out_tdata,
  // zero_total
  output logic                               out_tuser,
  input  logic                               cfg_we,
  input  logic [lcs_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [lcs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int SB = lcs_pkg::SAMPLE_BITS;

  logic [lcs_pkg::BASE_W-1:0]  base_r;
  logic [lcs_pkg::GAIN_W-1:0]  gain_r;

  logic [SB-1:0]               s0, s1, s2, s3, s4;
  logic [lcs_pkg::MAG_W-1:0]   pos_sum, neg_sum, mag_nxt;
  logic [lcs_pkg::PSUM_W-1:0]  psum_nxt;
  logic                        neg_nxt;

  logic                        v1_r, v2_r, v3_r;
  logic                        en1, en2, en3;
  logic [lcs_pkg::MAG_W-1:0]   mag1_r;
  logic [lcs_pkg::PSUM_W-1:0]  psum1_r, psum2_r, psum3_r;
  lcs_pkg::lcs_side_t          side1_r, side2_r, side3_r;
  logic [lcs_pkg::P1_W-1:0]    prod2_r;
  logic [lcs_pkg::P2_W-1:0]    prod3_r;

  logic                        div_in_ready, div_out_valid, div_out_ready;
  logic [lcs_pkg::Q_W-1:0]     div_quo;
  lcs_pkg::lcs_side_t          div_side;

  logic                        out_valid_r;
  logic [lcs_pkg::OUT_W-1:0]   left_r, right_r, left_nxt, right_nxt;
  logic                        zero_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= lcs_pkg::BASE_RESET;
      gain_r <= lcs_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      unique case (lcs_pkg::cfg_idx_t'(cfg_addr))
        lcs_pkg::CFG_BASE_SPEED: base_r <= cfg_wdata[lcs_pkg::BASE_W-1:0];
        lcs_pkg::CFG_GAIN_Q16:   gain_r <= cfg_wdata[lcs_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // stage enables, back to front
  assign en3       = !v3_r || div_in_ready;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;

  // unpack samples
  assign s0 = in_tdata[0*SB +: SB];
  assign s1 = in_tdata[1*SB +: SB];
  assign s2 = in_tdata[2*SB +: SB];
  assign s3 = in_tdata[3*SB +: SB];
  assign s4 = in_tdata[4*SB +: SB];

  // weighted sum as sign and magnitude, plain sum
  always_comb begin
    pos_sum  = lcs_pkg::MAG_W'(s3) + {1'b0, s4, 1'b0};
    neg_sum  = lcs_pkg::MAG_W'(s1) + {1'b0, s0, 1'b0};
    neg_nxt  = neg_sum > pos_sum;
    mag_nxt  = neg_nxt ? (neg_sum - pos_sum) : (pos_sum - neg_sum);
    psum_nxt = lcs_pkg::PSUM_W'(s0) + lcs_pkg::PSUM_W'(s1) + lcs_pkg::PSUM_W'(s2)
             + lcs_pkg::PSUM_W'(s3) + lcs_pkg::PSUM_W'(s4);
  end

  // valid bits of the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // sums, then magnitude times gain, then times base
  always_ff @(posedge clk) begin
    if (en1) begin
      mag1_r       <= mag_nxt;
      psum1_r      <= psum_nxt;
      side1_r.neg  <= neg_nxt;
      side1_r.zero <= (psum_nxt == '0);
      side1_r.base <= base_r;
    end
    if (en2) begin
      prod2_r <= lcs_pkg::P1_W'(mag1_r) * lcs_pkg::P1_W'(gain_r);
      psum2_r <= psum1_r;
      side2_r <= side1_r;
    end
    if (en3) begin
      prod3_r <= lcs_pkg::P2_W'(prod2_r) * lcs_pkg::P2_W'(side2_r.base);
      psum3_r <= psum2_r;
      side3_r <= side2_r;
    end
  end

  // divide scaled product by the plain sum
  lcs_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .in_ready  (div_in_ready),
    .in_num    (prod3_r[lcs_pkg::P2_W-1:lcs_pkg::GAIN_W]),
    .in_den    (psum3_r),
    .in_side   (side3_r),
    .out_valid (div_out_valid),
    .out_ready (div_out_ready),
    .out_quo   (div_quo),
    .out_side  (div_side)
  );

  assign div_out_ready = !out_valid_r || out_tready;

  // apply signed correction to both motors
  always_comb begin
    logic [lcs_pkg::OUT_W-1:0] corr, base_ext;
    corr     = div_side.zero ? '0 : lcs_pkg::OUT_W'(div_quo);
    base_ext = lcs_pkg::OUT_W'(div_side.base);
    if (div_side.neg) begin
      left_nxt  = base_ext + corr;
      right_nxt = base_ext - corr;
    end else begin
      left_nxt  = base_ext - corr;
      right_nxt = base_ext + corr;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (div_out_ready) begin
      out_valid_r <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_out_ready) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
      zero_r  <= div_side.zero;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(lcs_pkg::OUT_DATA_W - 2 * lcs_pkg::OUT_W){1'b0}}, right_r, left_r};
  assign out_tuser  = zero_r;

endmodule

[sv/lcs_chk.sv]
// ---------------------------------------------------------------------------
// lcs_chk
// Port-level checks for the line centroid steering block
// ---------------------------------------------------------------------------
module lcs_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [lcs_pkg::OUT_DATA_W-1:0]     out_tdata,
  input logic                               out_tuser
);

  localparam int OW = lcs_pkg::OUT_W;

  // no result beat straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat right after reset");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result beat changed");

  // zero sample sum leaves both motors at the same speed
  a_zero_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[OW-1:0] == out_tdata[2*OW-1:OW])
    else $error("zero sum but motor speeds differ");

  // left plus right is twice the base, so the low bits agree
  a_sum_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[0] == out_tdata[OW])
    else $error("motor speeds not symmetric about base");

endmodule

bind line_centroid_p_steering lcs_chk u_lcs_chk (.*);

[sim/line_centroid_p_steering_tb.sv]
// ---------------------------------------------------------------------------
// line_centroid_p_steering_tb
// Self-checking bench for the line centroid steering block
// ---------------------------------------------------------------------------
// Sensor frames go in on the input stream. A software copy of the steering
// law predicts left and right speeds and the zero-sum flag for every accepted
// frame, and each output beat is checked in order against the oldest
// prediction. Register settings change only while the pipe is empty. Both
// stream sides idle at random, and one long output stall fills the pipe.
// ---------------------------------------------------------------------------
module line_centroid_p_steering_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB = lcs_pkg::SAMPLE_BITS;
  localparam int NS = lcs_pkg::NUM_SENSORS;
  localparam int OW = lcs_pkg::OUT_W;

  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_FRAMES  = 250;
  localparam logic [SB-1:0] S_MAX = '1;

  typedef logic [NS-1:0][SB-1:0] frame_t;

  typedef struct packed {
    logic signed [OW-1:0] left_rpm;
    logic signed [OW-1:0] right_rpm;
    logic                 zero_total;
  } steer_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  // sensor_0, sensor_1, sensor_2, sensor_3, sensor_4, zero fill
  logic [lcs_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                           out_tvalid;
  logic                           out_tready;
  // left_rpm, right_rpm, zero fill
  logic [lcs_pkg::OUT_DATA_W-1:0] out_tdata;
  // zero_total
  logic                           out_tuser;
  logic                           cfg_we;
  logic [lcs_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [lcs_pkg::CFG_DATA_W-1:0] cfg_wdata;

  // bench copy of the registers
  logic [lcs_pkg::BASE_W-1:0] cur_base;
  logic [lcs_pkg::GAIN_W-1:0] cur_gain;

  steer_t steer_q[$];

  bit src_idle;
  bit sink_idle;
  int hold_req;
  int fail_count;
  int frame_count;
  int zero_frames;
  int beat_count;
  int cfg_writes;
  int max_hold;
  int cycle_count;

  line_centroid_p_steering dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("line_centroid_p_steering_tb NOT OK");
      $finish;
    end
  end

  // steering law: weighted centroid times gain and base, truncated to zero
  function automatic steer_t predict_steer(frame_t f);
    longint wsum;
    longint psum;
    longint mag;
    longint corr;
    steer_t r;
    wsum = 0;
    psum = 0;
    corr = 0;
    for (int i = 0; i < NS; i++) begin
      wsum += longint'(i - 2) * longint'(f[i]);
      psum += longint'(f[i]);
    end
    if (psum != 0) begin
      mag  = (wsum < 0) ? -wsum : wsum;
      corr = (mag * longint'(cur_gain) * longint'(cur_base)) / (psum << lcs_pkg::GAIN_W);
      if (wsum < 0) corr = -corr;
    end
    r.left_rpm   = OW'(longint'(cur_base) - corr);
    r.right_rpm  = OW'(longint'(cur_base) + corr);
    r.zero_total = (psum == 0);
    return r;
  endfunction

  // mixture of frame shapes, weighted towards fully random samples
  function automatic frame_t random_frame();
    frame_t f;
    int lit;
    f = '0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        for (int i = 0; i < NS; i++) f[i] = SB'($urandom);
      end
      4: begin
        for (int i = 0; i < NS; i++) f[i] = $urandom_range(0, 1) ? S_MAX : '0;
      end
      5: begin
        for (int i = 0; i < NS; i++) f[i] = SB'($urandom_range(0, 2));
      end
      6: begin
        f[$urandom_range(0, NS - 1)] = SB'($urandom);
      end
      7: begin
        lit = $urandom_range(0, NS - 2);
        for (int i = 0; i < NS; i++) f[i] = SB'($urandom_range(0, 40));
        f[lit]     = SB'($urandom_range(600, 1023));
        f[lit + 1] = SB'($urandom_range(600, 1023));
      end
      8: begin
        for (int i = 0; i < NS; i++) f[i] = SB'($urandom_range(1000, 1023));
      end
      default: begin
        for (int i = 0; i < NS; i++) f[i] = $urandom_range(0, 1) ? SB'($urandom) : '0;
      end
    endcase
    return f;
  endfunction

  // offer one frame and wait for its beat
  task automatic send_frame(frame_t f);
    int gap;
    steer_t want;
    gap = src_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    want = predict_steer(f);
    in_tvalid <= 1'b1;
    in_tdata  <= lcs_pkg::IN_DATA_W'(f);
    do @(posedge clk); while (!in_tready);
    steer_q.push_back(want);
    frame_count++;
    if (want.zero_total) zero_frames++;
  endtask

  // close a burst and let the pipe empty
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (steer_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, pipe assumed empty
  task automatic cfg_write(lcs_pkg::cfg_idx_t idx, logic [lcs_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    case (idx)
      lcs_pkg::CFG_BASE_SPEED: cur_base = val[lcs_pkg::BASE_W-1:0];
      lcs_pkg::CFG_GAIN_Q16:   cur_gain = val[lcs_pkg::GAIN_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // corner frames under the reset settings
  task automatic test_directed_frames();
    frame_t f;
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    send_frame('0);
    send_frame({NS{S_MAX}});
    f = '0; f[0] = S_MAX;            send_frame(f);
    f = '0; f[4] = S_MAX;            send_frame(f);
    f = '0; f[2] = S_MAX;            send_frame(f);
    f = '0; f[1] = SB'(1);           send_frame(f);
    f = '0; f[3] = SB'(1);           send_frame(f);
    f = '0; f[0] = SB'(1); f[4] = SB'(1); send_frame(f);
    f = '0; f[0] = SB'(1); f[3] = SB'(1); send_frame(f);
    f = '0; f[0] = S_MAX; f[1] = S_MAX; send_frame(f);
    f = '0; f[3] = S_MAX; f[4] = S_MAX; send_frame(f);
    f = {10'h2aa, 10'h155, 10'h2aa, 10'h155, 10'h2aa}; send_frame(f);
    f = {NS{10'h200}};                send_frame(f);
    wait_drained();
  endtask

  // hard left, hard right and an empty frame under extreme and then random settings
  task automatic test_register_extremes();
    frame_t left_hit;
    frame_t right_hit;
    left_hit  = '0; left_hit[0]  = S_MAX;
    right_hit = '0; right_hit[4] = S_MAX;
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    for (int k = 0; k < 5; k++) begin
      case (k)
        0: begin
          cfg_write(lcs_pkg::CFG_BASE_SPEED, 16'h0000);
          cfg_write(lcs_pkg::CFG_GAIN_Q16, 16'h0000);
        end
        1: begin
          cfg_write(lcs_pkg::CFG_BASE_SPEED, 16'h03ff);
          cfg_write(lcs_pkg::CFG_GAIN_Q16, 16'hffff);
        end
        2: begin
          cfg_write(lcs_pkg::CFG_BASE_SPEED, 16'hffff);
          cfg_write(lcs_pkg::CFG_GAIN_Q16, 16'h0000);
        end
        3: begin
          cfg_write(lcs_pkg::CFG_BASE_SPEED, 16'hfc00);
          cfg_write(lcs_pkg::CFG_GAIN_Q16, 16'hffff);
        end
        default: begin
          cfg_write(lcs_pkg::CFG_BASE_SPEED, lcs_pkg::CFG_DATA_W'($urandom));
          cfg_write(lcs_pkg::CFG_GAIN_Q16, lcs_pkg::CFG_DATA_W'($urandom));
        end
      endcase
      send_frame(left_hit);
      send_frame(right_hit);
      send_frame('0);
      wait_drained();
    end
  endtask

  // random frames over a series of settings and idling patterns
  task automatic test_random_traffic();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0: cfg_write(lcs_pkg::CFG_BASE_SPEED, $urandom_range(0, 1) ? 16'h03ff : 16'h0000);
        default: cfg_write(lcs_pkg::CFG_BASE_SPEED, lcs_pkg::CFG_DATA_W'($urandom));
      endcase
      case ($urandom_range(0, 3))
        0: cfg_write(lcs_pkg::CFG_GAIN_Q16, $urandom_range(0, 1) ? 16'hffff : 16'h0000);
        default: cfg_write(lcs_pkg::CFG_GAIN_Q16, lcs_pkg::CFG_DATA_W'($urandom));
      endcase
      src_idle  = p[0];
      sink_idle = p[1];
      for (int n = 0; n < PHASE_FRAMES; n++) send_frame(random_frame());
      wait_drained();
    end
  endtask

  // long output stall while frames keep coming, so the pipe fills up
  task automatic test_output_backpressure();
    cfg_write(lcs_pkg::CFG_BASE_SPEED, 16'd300);
    cfg_write(lcs_pkg::CFG_GAIN_Q16, 16'd20000);
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    hold_req  = 300;
    for (int n = 0; n < 40; n++) send_frame(random_frame());
    wait_drained();
  endtask

  // output side: random stall per beat, or one long hold on request
  initial begin : sink
    int stall;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req > 0) begin
        stall    = hold_req;
        hold_req = 0;
        if (stall > max_hold) max_hold = stall;
      end else begin
        stall = sink_idle ? $urandom_range(0, 15) : 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // compare each output beat with the oldest prediction
  always @(posedge clk) begin
    steer_t want;
    steer_t got;
    if (rst_n && out_tvalid && out_tready) begin
      beat_count++;
      got.left_rpm   = out_tdata[OW-1:0];
      got.right_rpm  = out_tdata[2*OW-1:OW];
      got.zero_total = out_tuser;
      if (steer_q.size() == 0) begin
        $error("unexpected output beat: left_rpm %0d right_rpm %0d zero_total %0d",
               got.left_rpm, got.right_rpm, got.zero_total);
        fail_count++;
      end else begin
        want = steer_q.pop_front();
        if (got.left_rpm !== want.left_rpm) begin
          $error("left_rpm: expected %0d, got %0d", want.left_rpm, got.left_rpm);
          fail_count++;
        end
        if (got.right_rpm !== want.right_rpm) begin
          $error("right_rpm: expected %0d, got %0d", want.right_rpm, got.right_rpm);
          fail_count++;
        end
        if (got.zero_total !== want.zero_total) begin
          $error("zero_total: expected %0d, got %0d", want.zero_total, got.zero_total);
          fail_count++;
        end
      end
    end
  end

  // reset, tests in turn, verdict
  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= lcs_pkg::CFG_BASE_SPEED;
    cfg_wdata <= '0;
    cur_base  = lcs_pkg::BASE_RESET;
    cur_gain  = lcs_pkg::GAIN_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_frames();
    test_register_extremes();
    test_random_traffic();
    test_output_backpressure();

    if (steer_q.size() != 0) begin
      $error("%0d predicted beats never arrived", steer_q.size());
      fail_count++;
    end
    $display("frames sent %0d (%0d with zero sample sum), beats checked %0d",
             frame_count, zero_frames, beat_count);
    $display("register writes %0d, longest output hold %0d cycles, mismatches %0d",
             cfg_writes, max_hold, fail_count);
    if (fail_count == 0) begin
      $display("line_centroid_p_steering_tb OK");
    end else begin
      $display("line_centroid_p_steering_tb NOT OK");
    end
    $finish;
  end

endmodule
